// File: rtl/core/swrr_pkg.sv
// ----------------------------------------------------------------------------
// swrr_pkg: shared types and constants of the reorder receiver
// Widths of the packet and result fields, packet type codes, slot record
// layout and sequencer states.
// ----------------------------------------------------------------------------
package swrr_pkg;

  localparam int WIN_MAX = 16;
  localparam int SLOT_W  = (WIN_MAX > 1) ? $clog2(WIN_MAX) : 1;
  localparam int CNT_W   = $clog2(WIN_MAX + 1);
  localparam int WS_W    = 5;
  localparam int TYPE_W  = 2;
  localparam int SEQ_W   = 32;
  localparam int LEN_W   = 11;
  localparam int HND_W   = 16;

  localparam logic [LEN_W-1:0] PAYLOAD_MAX = LEN_W'(1456);

  typedef enum logic [TYPE_W-1:0] {
    PKT_START = 2'd0,
    PKT_END   = 2'd1,
    PKT_DATA  = 2'd2,
    PKT_ACK   = 2'd3
  } pkt_type_t;

  localparam logic KIND_DELIVER = 1'b0;
  localparam logic KIND_ACK     = 1'b1;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [HND_W-1:0] handle;
    logic [LEN_W-1:0] length;
  } slot_t;

  localparam int SLOT_BITS = $bits(slot_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WALK,
    ST_ECHO
  } st_t;

endpackage

// File: rtl/core/swrr_in_if.sv
// ----------------------------------------------------------------------------
// swrr_in_if: received packet header channel
// valid/ready channel carrying one packet header per beat.
// ----------------------------------------------------------------------------
interface swrr_in_if
  import swrr_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [TYPE_W-1:0] pkt_type;
  logic [SEQ_W-1:0]  seq_num;
  logic [LEN_W-1:0]  payload_length;
  logic              checksum_ok;
  logic [HND_W-1:0]  payload_handle;

  modport source (output valid, pkt_type, seq_num, payload_length, checksum_ok,
                  payload_handle, input ready);
  modport sink   (input valid, pkt_type, seq_num, payload_length, checksum_ok,
                  payload_handle, output ready);
endinterface

// File: rtl/core/swrr_out_if.sv
// ----------------------------------------------------------------------------
// swrr_out_if: delivery and ack channel
// valid/ready channel carrying one delivery or ack per beat.
// ----------------------------------------------------------------------------
interface swrr_out_if
  import swrr_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             kind;
  logic [SEQ_W-1:0] out_seq;
  logic [HND_W-1:0] out_handle;
  logic [LEN_W-1:0] out_length;
  logic             last;

  modport source (output valid, kind, out_seq, out_handle, out_length, last,
                  input ready);
  modport sink   (input valid, kind, out_seq, out_handle, out_length, last,
                  output ready);
endinterface

// File: rtl/core/swrr_cfg_if.sv
// ----------------------------------------------------------------------------
// swrr_cfg_if: window size write channel
// valid/ready channel carrying the receive window size.
// ----------------------------------------------------------------------------
interface swrr_cfg_if
  import swrr_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [WS_W-1:0] win_len;

  modport source (output valid, win_len, input ready);
  modport sink   (input valid, win_len, output ready);
endinterface

// File: rtl/core/swrr_ram.sv
// ----------------------------------------------------------------------------
// swrr_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module swrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/core/sliding_window_reorder_receiver.sv
// ----------------------------------------------------------------------------
// sliding_window_reorder_receiver: selective-repeat receive window
// Stores good data packets that fall in the window into a ring of slots,
// releases in-order slots as deliveries and answers with acks.
// ----------------------------------------------------------------------------
//
//  channel | dir | beat carries
//  --------+-----+-------------------------------------------------------
//  pkt     | in  | pkt_type, seq_num, payload_length, checksum_ok, handle
//  res     | out | kind, out_seq, out_handle, out_length, last
//  cfg     | in  | win_len (clamped to 1..WIN_MAX, drops held slots)
//
// Sequence: one packet at a time. Accept in idle (with the slot write),
// RAM read of the head slot, then the walk: a delivery per released slot,
// the cumulative ack and, for an end packet, an end echo. A packet taken
// before start (other than a start, which goes on to its echo) or after end
// stops at its accept. The walk is bound by the slot RAM's single read port.
// Reset clears valid bits, head, expected sequence, start/end flags and sets
// the window to WIN_MAX. Slot RAM contents need no clearing.
// A stalled result port holds the walk in place; pkt is taken only in idle.
// ----------------------------------------------------------------------------
module sliding_window_reorder_receiver
  import swrr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  swrr_in_if.sink    pkt,
  swrr_out_if.source res,
  swrr_cfg_if.sink   cfg
);

  // Control state
  st_t               state, state_next;
  logic [CNT_W-1:0]  win;          // window in use, 1..WIN_MAX
  logic [SLOT_W-1:0] head_slot;
  logic [SEQ_W-1:0]  expected_seq;
  logic              started;
  logic              finished;
  logic [WIN_MAX-1:0] slot_valid;
  logic [CNT_W-1:0]  walk_cnt;     // slots released for this packet

  // Latched packet
  logic [SEQ_W-1:0]  it_seq;
  logic              it_end;

  // Output register
  logic              o_valid;
  logic              o_kind;
  logic [SEQ_W-1:0]  o_seq;
  logic [HND_W-1:0]  o_handle;
  logic [LEN_W-1:0]  o_length;
  logic              o_last;

  // Slot RAM ports
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  slot_t             ram_wdata;
  logic [SLOT_W-1:0] ram_raddr;
  slot_t             ram_rdata;

  swrr_ram #(
    .WIDTH (SLOT_BITS),
    .DEPTH (WIN_MAX)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Handshakes
  logic pkt_acc, cfg_acc, ospace;
  assign pkt_acc = pkt.valid && pkt.ready;
  assign cfg_acc = cfg.valid && cfg.ready;
  assign ospace  = !o_valid || res.ready;
  assign cfg.ready = 1'b1;

  // Window placement of an incoming data packet
  logic [SEQ_W-1:0]  offset;
  logic              in_win;
  logic [CNT_W:0]    pos_sum;
  logic [SLOT_W-1:0] store_slot;
  logic              store;

  assign offset  = pkt.seq_num - expected_seq;
  assign in_win  = offset < SEQ_W'(win);
  assign pos_sum = (CNT_W+1)'(head_slot) + (CNT_W+1)'(offset[CNT_W-1:0]);
  assign store_slot = (pos_sum >= (CNT_W+1)'(win)) ?
                      SLOT_W'(pos_sum - (CNT_W+1)'(win)) : SLOT_W'(pos_sum);
  assign store = pkt_acc && !finished && started &&
                 (pkt.pkt_type == PKT_DATA) && pkt.checksum_ok && in_win;

  assign ram_we          = store;
  assign ram_waddr       = store_slot;
  assign ram_wdata.seq   = pkt.seq_num;
  assign ram_wdata.handle = pkt.payload_handle;
  assign ram_wdata.length = (pkt.payload_length > PAYLOAD_MAX) ?
                            PAYLOAD_MAX : pkt.payload_length;

  // Head advance, wrapping at the window size
  logic [CNT_W-1:0]  head_plus;
  logic [SLOT_W-1:0] head_inc;
  assign head_plus = CNT_W'(head_slot) + CNT_W'(1);
  assign head_inc  = (head_plus >= win) ? '0 : SLOT_W'(head_plus);

  // Next in-order slot present at the head?
  logic hit;
  assign hit = slot_valid[head_slot] && (ram_rdata.seq == expected_seq) &&
               (walk_cnt < win);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (pkt_acc && !finished) begin
          if (!started) begin
            if (pkt.pkt_type == PKT_START) state_next = ST_ECHO;
          end else begin
            state_next = ST_READ;
          end
        end
      end
      ST_READ: state_next = ST_WALK;
      ST_WALK: begin
        if (!hit && ospace) state_next = it_end ? ST_ECHO : ST_IDLE;
      end
      ST_ECHO: begin
        if (ospace) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  logic             release_slot;
  logic             ld;
  logic             ld_kind;
  logic [SEQ_W-1:0] ld_seq;
  logic [HND_W-1:0] ld_handle;
  logic [LEN_W-1:0] ld_length;
  logic             ld_last;

  always_comb begin
    pkt.ready    = 1'b0;
    ram_raddr    = head_slot;
    release_slot = 1'b0;
    ld           = 1'b0;
    ld_kind      = KIND_ACK;
    ld_seq       = expected_seq;
    ld_handle    = '0;
    ld_length    = '0;
    ld_last      = 1'b1;
    case (state)
      ST_IDLE: pkt.ready = 1'b1;
      ST_READ: ;
      ST_WALK: begin
        if (ospace) begin
          ld = 1'b1;
          if (hit) begin
            release_slot = 1'b1;
            ram_raddr    = head_inc;   // prefetch the next head
            ld_kind      = KIND_DELIVER;
            ld_seq       = ram_rdata.seq;
            ld_handle    = ram_rdata.handle;
            ld_length    = ram_rdata.length;
            ld_last      = 1'b0;
          end else begin
            ld_last = !it_end;         // cumulative ack
          end
        end
      end
      ST_ECHO: begin
        ld     = ospace;
        ld_seq = it_seq;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      win          <= CNT_W'(WIN_MAX);
      head_slot    <= '0;
      expected_seq <= '0;
      started      <= 1'b0;
      finished     <= 1'b0;
      slot_valid   <= '0;
      walk_cnt     <= '0;
      o_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_acc) begin
        if (cfg.win_len == '0) begin
          win <= CNT_W'(1);
        end else if (int'(cfg.win_len) > WIN_MAX) begin
          win <= CNT_W'(WIN_MAX);
        end else begin
          win <= CNT_W'(cfg.win_len);
        end
        slot_valid <= '0;
        head_slot  <= '0;
      end else begin
        if (store) slot_valid[store_slot] <= 1'b1;
        if (release_slot) begin
          slot_valid[head_slot] <= 1'b0;
          head_slot             <= head_inc;
        end
      end
      if (release_slot) begin
        expected_seq <= expected_seq + SEQ_W'(1);
        walk_cnt     <= walk_cnt + CNT_W'(1);
      end else if (state == ST_READ) begin
        walk_cnt <= '0;
      end
      if (state == ST_ECHO && ospace) begin
        // pre-start echo opens the stream, end echo closes it
        finished <= finished | started;
        started  <= 1'b1;
      end
      if (ld) begin
        o_valid <= 1'b1;
      end else if (res.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (pkt_acc) begin
      it_seq <= pkt.seq_num;
      it_end <= (pkt.pkt_type == PKT_END);
    end
    if (ld) begin
      o_kind   <= ld_kind;
      o_seq    <= ld_seq;
      o_handle <= ld_handle;
      o_length <= ld_length;
      o_last   <= ld_last;
    end
  end

  assign res.valid      = o_valid;
  assign res.kind       = o_kind;
  assign res.out_seq    = o_seq;
  assign res.out_handle = o_handle;
  assign res.out_length = o_length;
  assign res.last       = o_last;

  // Checks
  a_release_step: assert property (@(posedge clk) disable iff (rst)
    release_slot |=> expected_seq == $past(expected_seq) + SEQ_W'(1))
    else $error("expected sequence did not step on release");

  a_end_after_start: assert property (@(posedge clk) disable iff (rst)
    finished |-> started)
    else $error("finished without start");

  a_head_in_window: assert property (@(posedge clk) disable iff (rst)
    CNT_W'(head_slot) < win)
    else $error("head slot outside window");

  a_ack_empty: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.kind == KIND_ACK) |->
      (res.out_handle == '0 && res.out_length == '0))
    else $error("ack carries payload fields");

endmodule
